[rtl/core/tfr_pkg.sv]
// Package for the thruster frame receiver: sizes, field codes, reset values
// and the throttle-to-DShot mapping. Depends on nothing; every RTL file of
// the block refers to it by scoped names.
`timescale 1ns / 1ps

package tfr_pkg;

   // Number of motors carried by one frame and stored in the receiver.
   localparam int MOTOR_COUNT = 8;
   // At most eight motors are reported per burst.
   localparam int EMIT_COUNT = (MOTOR_COUNT < 8) ? MOTOR_COUNT : 8;
   localparam int MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam int EMIT_IDX_W = (EMIT_COUNT > 1) ? $clog2(EMIT_COUNT) : 1;

   // Frame layout: start byte, two bytes per motor, checksum byte.
   localparam int FRAME_DATA_BYTES = 2 * MOTOR_COUNT;
   localparam int CHECK_POS = FRAME_DATA_BYTES + 1;
   localparam int POS_W = $clog2(CHECK_POS + 1);

   // Fixed field widths.
   localparam int BYTE_W = 8;
   localparam int THROTTLE_W = 16;
   localparam int DSHOT_W = 11;
   localparam int MOTOR_INDEX_W = 3;
   localparam int IDLE_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   // Input kind carried in tuser.
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Result cause carried in tuser.
   localparam logic CAUSE_FRAME = 1'b0;
   localparam logic CAUSE_TIMEOUT = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_START_BYTE = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   // Reset values.
   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h5A;
   localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'd200;
   localparam logic [IDLE_W-1:0] IDLE_MAX = 16'hFFFF;

   // Throttle and command constants.
   localparam logic [THROTTLE_W-1:0] THR_NEUTRAL = 16'd1000;
   localparam logic [THROTTLE_W-1:0] THR_MAX_FWD = 16'd2000;
   localparam logic [THROTTLE_W-1:0] DS_MAX_REV = 16'd1047;
   // Forward offset: t - 1000 - 1 + 1048.
   localparam logic [THROTTLE_W-1:0] DS_FWD_OFFSET = 16'd47;
   localparam logic [DSHOT_W-1:0] DS_NEUTRAL = 11'd0;

   typedef logic [THROTTLE_W-1:0] throttle_array_type [MOTOR_COUNT];

   // Request from the frame parser to the burst emitter.
   typedef struct packed {
      logic load;     // latch new throttles and start a result burst
      logic timeout;  // burst is a timeout: all motors go neutral
   } load_ctl_type;

   // Neutral maps to zero, forward to 1048..2047, reverse to 1047..48,
   // anything outside the valid range to zero.
   function automatic logic [DSHOT_W-1:0] to_dshot(input logic [THROTTLE_W-1:0] t);
      logic [THROTTLE_W-1:0] value;
      begin
         if (t == THR_NEUTRAL) begin
            value = {THROTTLE_W{1'b0}};
         end else if (t > THR_NEUTRAL && t <= THR_MAX_FWD) begin
            value = t + DS_FWD_OFFSET;
         end else if (t < THR_NEUTRAL) begin
            value = DS_MAX_REV - t;
         end else begin
            value = {THROTTLE_W{1'b0}};
         end
         to_dshot = value[DSHOT_W-1:0];
      end
   endfunction

endpackage

[rtl/core/tfr_emitter.sv]
// Burst emitter of the thruster frame receiver: holds the motor throttles and
// plays them out one motor per result transaction. Depends on tfr_pkg.
`timescale 1ns / 1ps

module tfr_emitter (
   input  logic                                     clock,
   input  logic                                     reset,
   input  tfr_pkg::load_ctl_type                    load_ctl,
   input  tfr_pkg::throttle_array_type              new_words,
   output logic                                     free,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // [2:0] motor_index, [18:3] throttle_word, [29:19] motor_command, [31:30] zero
   output logic [tfr_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   // [0] cause
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast
);

   logic [tfr_pkg::THROTTLE_W-1:0] motor_ff [tfr_pkg::MOTOR_COUNT];
   logic                           busy_ff;
   logic                           busy_in;
   logic [tfr_pkg::EMIT_IDX_W-1:0] idx_ff;
   logic [tfr_pkg::EMIT_IDX_W-1:0] idx_in;
   logic                           cause_ff;
   logic [tfr_pkg::THROTTLE_W-1:0] cur_throttle;
   logic [tfr_pkg::DSHOT_W-1:0]    cur_dshot;
   logic                           last_beat;
   logic                           beat_done;

   assign last_beat = (idx_ff == tfr_pkg::EMIT_IDX_W'(tfr_pkg::EMIT_COUNT - 1));
   assign beat_done = busy_ff && rsp_tready;
   assign free = !busy_ff || (rsp_tready && last_beat);

   always_comb begin
      busy_in = busy_ff;
      idx_in = idx_ff;
      if (load_ctl.load) begin
         busy_in = 1'b1;
         idx_in = '0;
      end else if (beat_done) begin
         if (last_beat) begin
            busy_in = 1'b0;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
         cause_ff <= tfr_pkg::CAUSE_FRAME;
         for (int m = 0; m < tfr_pkg::MOTOR_COUNT; m++) begin
            motor_ff[m] <= tfr_pkg::THR_NEUTRAL;
         end
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
         if (load_ctl.load) begin
            cause_ff <= load_ctl.timeout ? tfr_pkg::CAUSE_TIMEOUT : tfr_pkg::CAUSE_FRAME;
            for (int m = 0; m < tfr_pkg::MOTOR_COUNT; m++) begin
               motor_ff[m] <= load_ctl.timeout ? tfr_pkg::THR_NEUTRAL : new_words[m];
            end
         end
      end
   end

   assign cur_throttle = motor_ff[tfr_pkg::MOTOR_IDX_W'(idx_ff)];
   assign cur_dshot = tfr_pkg::to_dshot(cur_throttle);

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata = {2'b00, cur_dshot, cur_throttle,
                       tfr_pkg::MOTOR_INDEX_W'(idx_ff)};
   assign rsp_tuser = cause_ff;
   assign rsp_tlast = last_beat;

endmodule

[rtl/core/thruster_frame_receiver.sv]
// Top level of the thruster frame receiver: input register, frame parser,
// timeout counter and configuration registers. Depends on tfr_pkg and
// instantiates tfr_emitter.
`timescale 1ns / 1ps

// The receiver takes one transaction per clock on the req channel, a link
// byte (tuser 0) or a one millisecond tick (tuser 1), unless a held item waits
// for the emitter. Each transaction lands in an input register and is handled
// from there. Bytes are hunted for the start byte, then two little-endian
// bytes per motor and an XOR checksum over all earlier frame bytes are
// collected. A frame with a good checksum latches the new throttles, restarts
// the timeout and sends a burst of eight result transactions (one per motor,
// motor 0 first, tlast on the final one, tuser 0). A frame with a bad checksum
// is dropped silently. When more than timeout_ticks ticks pass without a good
// frame, every motor goes to neutral (1000), the parse restarts and a burst
// with tuser 1 is sent once. Bytes and ticks that produce no results flow at
// one per cycle even while a burst is being sent; an item that starts a burst
// waits in the input register until the last result of the current burst is
// taken. The completing transaction passes the input register, then loads the
// emitter, whose registers drive the first result. Configuration writes on the
// csr channel are always accepted and should be issued only while the receiver
// is idle.

module thruster_frame_receiver (
   input  logic                                clock,
   input  logic                                reset,
   // Input transactions.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] data_byte
   input  logic [tfr_pkg::BYTE_W-1:0]          req_tdata,
   // [0] func
   input  logic                                req_tuser,
   // Result transactions.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] motor_index, [18:3] throttle_word, [29:19] motor_command, [31:30] zero
   output logic [tfr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] cause
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   // Configuration writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [tfr_pkg::CSR_DATA_W-1:0]      csr_data
);

   // Configuration registers.
   logic [tfr_pkg::BYTE_W-1:0]     start_ff;
   logic [tfr_pkg::IDLE_W-1:0]     timeout_ff;

   // Input register.
   logic                           hold_valid_ff;
   logic                           hold_valid_in;
   logic                           hold_func_ff;
   logic [tfr_pkg::BYTE_W-1:0]     hold_byte_ff;

   // Parser and timeout state.
   logic [tfr_pkg::POS_W-1:0]      pos_ff;
   logic [tfr_pkg::POS_W-1:0]      pos_in;
   logic [tfr_pkg::BYTE_W-1:0]     xor_ff;
   logic [tfr_pkg::BYTE_W-1:0]     xor_in;
   logic [tfr_pkg::IDLE_W-1:0]     idle_ff;
   logic [tfr_pkg::IDLE_W-1:0]     idle_in;
   logic                           timed_out_ff;
   logic                           timed_out_in;

   // Pending frame words; every entry is written before it is copied.
   tfr_pkg::throttle_array_type    pending_ff;
   logic                           pend_we;
   logic                           pend_hi;
   logic [tfr_pkg::MOTOR_IDX_W-1:0] pend_idx;
   logic [tfr_pkg::POS_W-1:0]      pos_minus_one;

   logic                           req_fire;
   logic                           fire_timeout;
   logic                           frame_good;
   logic                           hold_emits;
   logic                           advance;
   logic                           emit_free;
   tfr_pkg::load_ctl_type          load_ctl;

   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // A tick fires the timeout once the idle count has reached the limit.
   assign fire_timeout = !timed_out_ff && (idle_ff >= timeout_ff);
   assign frame_good = (pos_ff == tfr_pkg::POS_W'(tfr_pkg::CHECK_POS))
                       && (xor_ff == hold_byte_ff);
   assign hold_emits = (hold_func_ff == tfr_pkg::FUNC_TICK) ? fire_timeout : frame_good;

   // The held item moves on unless it needs the emitter while a burst is
   // still in flight.
   assign advance = hold_valid_ff && (!hold_emits || emit_free);
   assign req_tready = !hold_valid_ff || advance;

   assign pos_minus_one = pos_ff - 1'b1;
   assign pend_idx = tfr_pkg::MOTOR_IDX_W'(pos_minus_one >> 1);
   assign pend_hi = !pos_ff[0];

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_fire) begin
         hold_valid_in = 1'b1;
      end else if (advance) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      xor_in = xor_ff;
      idle_in = idle_ff;
      timed_out_in = timed_out_ff;
      pend_we = 1'b0;
      load_ctl = '0;
      if (advance) begin
         if (hold_func_ff == tfr_pkg::FUNC_TICK) begin
            if (fire_timeout) begin
               pos_in = '0;
               xor_in = '0;
               timed_out_in = 1'b1;
               load_ctl.load = 1'b1;
               load_ctl.timeout = 1'b1;
            end else if (idle_ff != tfr_pkg::IDLE_MAX) begin
               idle_in = idle_ff + 1'b1;
            end
         end else if (pos_ff == '0) begin
            if (hold_byte_ff == start_ff) begin
               xor_in = hold_byte_ff;
               pos_in = tfr_pkg::POS_W'(1);
            end
         end else if (pos_ff <= tfr_pkg::POS_W'(tfr_pkg::FRAME_DATA_BYTES)) begin
            pend_we = 1'b1;
            xor_in = xor_ff ^ hold_byte_ff;
            pos_in = pos_ff + 1'b1;
         end else begin
            // Checksum byte: always back to hunting.
            pos_in = '0;
            xor_in = '0;
            if (frame_good) begin
               idle_in = '0;
               timed_out_in = 1'b0;
               load_ctl.load = 1'b1;
               load_ctl.timeout = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= tfr_pkg::START_BYTE_RESET;
         timeout_ff <= tfr_pkg::TIMEOUT_RESET;
         hold_valid_ff <= 1'b0;
         pos_ff <= '0;
         xor_ff <= '0;
         idle_ff <= '0;
         timed_out_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tfr_pkg::CSR_START_BYTE: begin
                  start_ff <= csr_data[tfr_pkg::BYTE_W-1:0];
               end
               tfr_pkg::CSR_TIMEOUT_TICKS: begin
                  timeout_ff <= csr_data;
               end
               default: begin
                  start_ff <= start_ff;
               end
            endcase
         end
         hold_valid_ff <= hold_valid_in;
         pos_ff <= pos_in;
         xor_ff <= xor_in;
         idle_ff <= idle_in;
         timed_out_ff <= timed_out_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hold_func_ff <= req_tuser;
         hold_byte_ff <= req_tdata;
      end
      if (pend_we) begin
         if (pend_hi) begin
            pending_ff[pend_idx] <= {hold_byte_ff, pending_ff[pend_idx][tfr_pkg::BYTE_W-1:0]};
         end else begin
            pending_ff[pend_idx] <= {{tfr_pkg::BYTE_W{1'b0}}, hold_byte_ff};
         end
      end
   end

   tfr_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load_ctl   (load_ctl),
      .new_words  (pending_ff),
      .free       (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A burst is only started when the emitter can take it.
   assert property (@(posedge clock) disable iff (reset)
      load_ctl.load |-> emit_free)
      else $error("burst started while emitter busy");

   // A timeout leaves the parser hunting with the timeout flag set.
   assert property (@(posedge clock) disable iff (reset)
      (advance && hold_func_ff == tfr_pkg::FUNC_TICK && fire_timeout)
      |=> (timed_out_ff && pos_ff == '0 && xor_ff == '0))
      else $error("timeout did not clear the parse");

   // Every result of a timeout burst reports a neutral throttle and command.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tfr_pkg::CAUSE_TIMEOUT)
      |-> (rsp_tdata[18:3] == tfr_pkg::THR_NEUTRAL && rsp_tdata[29:19] == tfr_pkg::DS_NEUTRAL))
      else $error("timeout burst carries a non-neutral motor");

   // A held item that waits for the emitter keeps the input stalled.
   assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && !advance) |-> !req_tready)
      else $error("input accepted over a stalled item");

endmodule

[tb/tb_thruster_frame_receiver.sv]
`timescale 1ns / 1ps
// Self-checking testbench for thruster_frame_receiver. It sends directed and random
// frame traffic under several register settings and checks every result transaction
// against a frame parser kept inside the bench. Depends on tfr_pkg and the receiver RTL.

module tb_thruster_frame_receiver;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 8;
   // Wait after the last expected command: items that cause no result can still sit
   // in the input register, so the bench lets them drain.
   localparam int SETTLE_CYCLES = 8;
   // Cycles with no transaction on any channel before the run is declared hung.
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 55;
   // First forward DShot command, the value that throttle 1001 maps to.
   localparam logic [15:0] DSHOT_FWD_BASE = 16'd1048;

   typedef struct {
      logic       func;
      logic [7:0] data;
   } link_item_type;

   typedef struct {
      logic [2:0]  motor;
      logic [15:0] throttle;
      logic [10:0] command;
      logic        cause;
      logic        last;
   } motor_cmd_type;

   // Every input starts at a known value. Reset is held from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = tfr_pkg::FUNC_BYTE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = tfr_pkg::CSR_START_BYTE;
   logic [15:0] csr_data = 16'h0000;

   link_item_type pending_items[$];   // bytes and ticks not yet offered to the receiver
   motor_cmd_type expected_cmds[$];   // motor commands the receiver still owes
   int         error_count = 0;
   int         items_queued = 0;
   logic [15:0] outgoing_words [tfr_pkg::MOTOR_COUNT];

   // Shadow copy of the receiver: its registers and its parse state.
   logic [7:0]  start_byte_cfg = tfr_pkg::START_BYTE_RESET;
   logic [15:0] timeout_cfg = tfr_pkg::TIMEOUT_RESET;
   int          frame_pos = 0;
   logic [7:0]  frame_xor = 8'h00;
   logic [15:0] staged_words [tfr_pkg::MOTOR_COUNT];
   logic [15:0] motor_throttle [tfr_pkg::MOTOR_COUNT];
   logic [15:0] ticks_since_frame = 16'h0000;
   logic        neutral_latched = 1'b0;

   thruster_frame_receiver DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      foreach (motor_throttle[i]) begin
         motor_throttle[i] = tfr_pkg::THR_NEUTRAL;
         staged_words[i] = 16'h0000;
      end
   end

   // Every mismatch goes through here: one line, and the failure is counted.
   task automatic flag_error(string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) begin
         flag_error($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   // Throttle to DShot: neutral gives 0, 1001..2000 give 1048..2047, 0..999 give
   // 1047..48 and anything above the forward range gives 0.
   function automatic logic [10:0] dshot_of(logic [15:0] throttle);
      if (throttle == tfr_pkg::THR_NEUTRAL) begin
         return 11'd0;
      end
      if (throttle > tfr_pkg::THR_NEUTRAL && throttle <= tfr_pkg::THR_MAX_FWD) begin
         return 11'(throttle - tfr_pkg::THR_NEUTRAL - 16'd1 + DSHOT_FWD_BASE);
      end
      if (throttle < tfr_pkg::THR_NEUTRAL) begin
         return 11'(tfr_pkg::DS_MAX_REV - throttle);
      end
      return 11'd0;
   endfunction

   // One command per reported motor, motor 0 first, last flag on the final one.
   task automatic queue_burst(logic cause);
      motor_cmd_type cmd;
      for (int k = 0; k < tfr_pkg::EMIT_COUNT; k++) begin
         cmd.motor = 3'(k);
         cmd.throttle = motor_throttle[k];
         cmd.command = dshot_of(motor_throttle[k]);
         cmd.cause = cause;
         cmd.last = (k == tfr_pkg::EMIT_COUNT - 1);
         expected_cmds.push_back(cmd);
      end
   endtask

   // Advances the shadow parser by one accepted transaction and queues the
   // commands that it causes.
   task automatic absorb_item(link_item_type item);
      int slot;
      if (item.func == tfr_pkg::FUNC_TICK) begin
         // The timeout fires once; after that ticks are quiet until a good frame.
         if (!neutral_latched && ticks_since_frame >= timeout_cfg) begin
            foreach (motor_throttle[i]) begin
               motor_throttle[i] = tfr_pkg::THR_NEUTRAL;
            end
            frame_pos = 0;
            frame_xor = 8'h00;
            neutral_latched = 1'b1;
            queue_burst(tfr_pkg::CAUSE_TIMEOUT);
         end else if (ticks_since_frame != tfr_pkg::IDLE_MAX) begin
            ticks_since_frame++;
         end
      end else if (frame_pos == 0) begin
         if (item.data == start_byte_cfg) begin
            frame_xor = item.data;
            frame_pos = 1;
         end
      end else if (frame_pos <= tfr_pkg::FRAME_DATA_BYTES) begin
         // Throttle words travel low byte first.
         slot = (frame_pos - 1) / 2;
         if (frame_pos % 2 == 1) begin
            staged_words[slot] = {8'h00, item.data};
         end else begin
            staged_words[slot][15:8] = item.data;
         end
         frame_xor ^= item.data;
         frame_pos++;
      end else begin
         // Checksum byte: the parse always returns to hunting afterwards.
         frame_pos = 0;
         if (frame_xor == item.data) begin
            motor_throttle = staged_words;
            ticks_since_frame = 16'h0000;
            neutral_latched = 1'b0;
            queue_burst(tfr_pkg::CAUSE_FRAME);
         end
         frame_xor = 8'h00;
      end
   endtask

   // Mostly no gap, sometimes a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return 0;
      end
      if (roll < 94) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Sender. A transaction stays on the bus until it is taken; the shadow parser
   // sees it at the edge where tvalid and tready are both high. Each signal gets at
   // most one nonblocking assignment per edge.
   int req_gap = 0;
   bit req_steady = 1'b0;

   always @(posedge clock) begin : req_driver
      link_item_type taken;
      link_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            taken.func = req_tuser;
            taken.data = req_tdata;
            absorb_item(taken);
         end
         if (!req_tvalid || req_tready) begin
            // Occasionally switch between idling at random and running flat out.
            if ($urandom_range(0, 63) == 0) begin
               req_steady = !req_steady;
            end
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               next_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_item.func;
               req_tdata <= next_item.data;
               req_gap = req_steady ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver side. Each result transaction is checked field by field against the
   // oldest expected command, then tready is stalled at random.
   int rsp_stall = 0;
   bit rsp_steady = 1'b0;

   always @(posedge clock) begin : rsp_monitor
      motor_cmd_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cmds.size() == 0) begin
               flag_error($sformatf("unexpected result transaction: tdata 0x%08h tuser %0b",
                                    rsp_tdata, rsp_tuser));
            end else begin
               want = expected_cmds.pop_front();
               compare_field("motor_index", rsp_tdata[2:0], want.motor);
               compare_field("throttle_word", rsp_tdata[18:3], want.throttle);
               compare_field("motor_command", rsp_tdata[29:19], want.command);
               compare_field("tdata padding", rsp_tdata[31:30], 0);
               compare_field("cause", rsp_tuser, want.cause);
               compare_field("last", rsp_tlast, want.last);
            end
         end
         if ($urandom_range(0, 63) == 0) begin
            rsp_steady = !rsp_steady;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall = rsp_steady ? 0 : pick_gap();
         end
      end
   end

   // Watchdog: a hung handshake anywhere ends the run.
   int quiet_cycles = 0;

   always @(posedge clock) begin : hang_watch
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("thruster_frame_receiver regression: fail");
            $finish;
         end
      end
   end

   task automatic push_byte(logic [7:0] value);
      link_item_type item;
      item.func = tfr_pkg::FUNC_BYTE;
      item.data = value;
      pending_items.push_back(item);
      items_queued++;
   endtask

   // The byte lane of a tick is ignored, so it carries random bits.
   task automatic push_tick();
      link_item_type item;
      item.func = tfr_pkg::FUNC_TICK;
      item.data = 8'($urandom);
      pending_items.push_back(item);
      items_queued++;
   endtask

   // Builds a complete frame from outgoing_words under the current start byte. A
   // corrupted frame gets one checksum bit flipped. Ticks may be slipped in between
   // bytes; they must not disturb the parse unless the timeout fires.
   task automatic add_frame(bit corrupt, int tick_pct);
      logic [7:0] sum;
      sum = start_byte_cfg;
      push_byte(start_byte_cfg);
      foreach (outgoing_words[k]) begin
         push_byte(outgoing_words[k][7:0]);
         push_byte(outgoing_words[k][15:8]);
         sum ^= outgoing_words[k][7:0] ^ outgoing_words[k][15:8];
         if ($urandom_range(0, 99) < tick_pct) begin
            push_tick();
         end
      end
      if (corrupt) begin
         sum ^= 8'(1 << $urandom_range(0, 7));
      end
      push_byte(sum);
   endtask

   // Throttles are weighted toward the mapping's region edges and neutral.
   function automatic logic [15:0] pick_throttle();
      case ($urandom_range(0, 9))
         0, 1: return tfr_pkg::THR_NEUTRAL;
         2, 3, 4: return 16'($urandom_range(1001, 2000));
         5, 6: return 16'($urandom_range(0, 999));
         7: return 16'($urandom_range(2001, 65535));
         8: return 16'($urandom);
         default: begin
            case ($urandom_range(0, 6))
               0: return 16'd0;
               1: return 16'd999;
               2: return 16'd1001;
               3: return 16'd2000;
               4: return 16'd2001;
               5: return 16'hFFFF;
               default: return 16'd1000;
            endcase
         end
      endcase
   endfunction

   // Random traffic: mostly well-formed frames with random throttles, some with a
   // bad checksum, plus cut-off frames, bursts of ticks and stray bytes.
   task automatic add_random_traffic(int budget);
      int goal;
      int choice;
      goal = items_queued + budget;
      while (items_queued < goal) begin
         choice = $urandom_range(0, 99);
         if (choice < 62) begin
            foreach (outgoing_words[k]) begin
               outgoing_words[k] = pick_throttle();
            end
            add_frame($urandom_range(0, 99) < 15, ($urandom_range(0, 3) == 0) ? 10 : 0);
         end else if (choice < 72) begin
            push_byte(start_byte_cfg);
            repeat ($urandom_range(1, tfr_pkg::FRAME_DATA_BYTES)) push_byte(8'($urandom));
         end else if (choice < 88) begin
            repeat ($urandom_range(1, 6)) push_tick();
         end else begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
         end
      end
   endtask

   // Writes one register once the receiver has taken the write, then updates the
   // shadow copy. Only called while nothing is in flight.
   task automatic write_register(logic index, logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      if (index == tfr_pkg::CSR_START_BYTE) begin
         start_byte_cfg = value[7:0];
      end else begin
         timeout_cfg = value;
      end
   endtask

   // Holds the sender back until every queued item has been taken and every expected
   // command has arrived, then lets the input register drain.
   task automatic wait_idle();
      @(posedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_cmds.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A zero timeout fires on the very first tick after a frame.
      write_register(tfr_pkg::CSR_TIMEOUT_TICKS, 16'd0);
      // One good frame that touches every region of the mapping, plus all-zero and
      // all-one bytes.
      outgoing_words[0] = 16'd0;
      outgoing_words[1] = 16'd999;
      outgoing_words[2] = 16'd1000;
      outgoing_words[3] = 16'd1001;
      outgoing_words[4] = 16'd2000;
      outgoing_words[5] = 16'd2001;
      outgoing_words[6] = 16'hFFFF;
      outgoing_words[7] = 16'h00FF;
      add_frame(1'b0, 0);
      // The first tick forces neutral, the second must stay quiet.
      push_tick();
      push_tick();
      // A bad checksum is dropped without any result.
      add_frame(1'b1, 0);
      wait_idle();

      // Random phases, each under its own register setting, the extremes included.
      // The sender is paused between phases until every command has come back.
      write_register(tfr_pkg::CSR_START_BYTE, 16'h0000);
      write_register(tfr_pkg::CSR_TIMEOUT_TICKS, 16'd1);
      add_random_traffic(PHASE_ITEMS);
      wait_idle();

      write_register(tfr_pkg::CSR_START_BYTE, 16'h00FF);
      write_register(tfr_pkg::CSR_TIMEOUT_TICKS, 16'hFFFF);
      add_random_traffic(PHASE_ITEMS);
      wait_idle();

      write_register(tfr_pkg::CSR_START_BYTE, 16'(tfr_pkg::START_BYTE_RESET));
      write_register(tfr_pkg::CSR_TIMEOUT_TICKS, 16'd0);
      add_random_traffic(PHASE_ITEMS);
      wait_idle();

      write_register(tfr_pkg::CSR_START_BYTE, 16'($urandom_range(0, 255)));
      write_register(tfr_pkg::CSR_TIMEOUT_TICKS, 16'($urandom_range(2, 10)));
      add_random_traffic(PHASE_ITEMS);
      wait_idle();

      write_register(tfr_pkg::CSR_START_BYTE, 16'($urandom_range(0, 255)));
      write_register(tfr_pkg::CSR_TIMEOUT_TICKS, tfr_pkg::TIMEOUT_RESET);
      add_random_traffic(PHASE_ITEMS);
      wait_idle();

      // Any late or extra result has had time to show up by now.
      if (error_count == 0) begin
         $display("thruster_frame_receiver regression: pass");
      end else begin
         $display("thruster_frame_receiver regression: fail");
      end
      $finish;
   end

endmodule

[thruster_frame_receiver.f]
rtl/core/tfr_pkg.sv
rtl/core/tfr_emitter.sv
rtl/core/thruster_frame_receiver.sv
tb/tb_thruster_frame_receiver.sv
